>>> hdl/bvhbox_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bvhbox_pkg;

  localparam int unsigned NodeAddrW  = 10;  // node_addr and leaf_node ports
  localparam int unsigned SkipW      = 11;  // node skip distance
  localparam int unsigned CountW     = 11;  // node_count register
  localparam int unsigned HitsW      = 7;   // max_hits port

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

endpackage

`default_nettype wire

>>> hdl/bvhbox_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bvhbox_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/bvh_box_overlap_query.sv
`timescale 1ns / 1ps
`default_nettype none

// Box overlap query over a flattened bounding-volume hierarchy.
// Input channel: an item is taken at a clock edge with start_i high and busy_o low.
//   op_i = write: the node box, leaf flag and skip are stored at node_addr_i;
//   busy_o stays low and no result follows.
//   op_i = query: the block walks the node table from node 0, one node per cycle,
//   and busy_o stays high until the walk is over.
// Result channel: valid_o marks each result for exactly one cycle; the receiver
// cannot stall. A hit is held until the next hit or the end of the walk, which
// decides whether it carries last_o.
// Each overlapping leaf is reported in walk order; the final result has last_o set.
// A query with no hit or a zero limit gives one result with hit_o low.
// The walk reads one node table entry per cycle through the single read port of
// the node memory, the next address following from the entry just read.
// cfg_we_i loads node_count; the user must write it only while no query is running, the block does not enforce it.
// Reset clears node_count and the walk control; the node table is not cleared and
// an entry must be written before a query reads it.

module bvh_box_overlap_query #(
  parameter int unsigned NODE_DEPTH = 1024,
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned HIT_LIMIT  = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [bvhbox_pkg::CountW-1:0]        cfg_wdata_i,
  input  wire logic                                 start_i,
  output      logic                                 busy_o,
  input  wire logic                                 op_i,
  input  wire logic [bvhbox_pkg::NodeAddrW-1:0]     node_addr_i,
  input  wire logic signed [COORD_BITS-1:0]         min_x_i,
  input  wire logic signed [COORD_BITS-1:0]         min_y_i,
  input  wire logic signed [COORD_BITS-1:0]         min_z_i,
  input  wire logic signed [COORD_BITS-1:0]         max_x_i,
  input  wire logic signed [COORD_BITS-1:0]         max_y_i,
  input  wire logic signed [COORD_BITS-1:0]         max_z_i,
  input  wire logic                                 node_is_leaf_i,
  input  wire logic [bvhbox_pkg::SkipW-1:0]         node_skip_i,
  input  wire logic [bvhbox_pkg::HitsW-1:0]         max_hits_i,
  output      logic                                 valid_o,
  output      logic [bvhbox_pkg::NodeAddrW-1:0]     leaf_node_o,
  output      logic                                 hit_o,
  output      logic                                 last_o
);

  localparam int unsigned AddrW  = $clog2(NODE_DEPTH);
  localparam int unsigned IdxW   = $clog2(NODE_DEPTH + 2048);
  localparam int unsigned LimW   = $clog2(HIT_LIMIT + 1);
  localparam int unsigned SkipW  = bvhbox_pkg::SkipW;
  localparam int unsigned EntryW = 6 * COORD_BITS + 1 + SkipW;

  // entry layout, lsb first: min x/y/z, max x/y/z, skip, leaf
  localparam int unsigned OffSkip = 6 * COORD_BITS;
  localparam int unsigned OffLeaf = OffSkip + SkipW;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWalk = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [bvhbox_pkg::CountW-1:0] node_count_q;

  logic signed [COORD_BITS-1:0] q_min_x_q, q_min_y_q, q_min_z_q;
  logic signed [COORD_BITS-1:0] q_max_x_q, q_max_y_q, q_max_z_q;
  logic [LimW-1:0]  limit_q, limit_d;
  logic [LimW-1:0]  n_q, n_d;
  logic [IdxW-1:0]  count_q, count_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic             pend_valid_q, pend_valid_d;
  logic [AddrW-1:0] pend_node_q, pend_node_d;

  logic                         out_valid_d, out_hit_d, out_last_d;
  logic [bvhbox_pkg::NodeAddrW-1:0] out_node_d;

  logic              accept;
  logic              wr_en;
  logic [EntryW-1:0] wr_entry;
  logic [EntryW-1:0] rd_entry;
  logic [AddrW-1:0]  rd_addr;

  logic signed [COORD_BITS-1:0] n_min_x, n_min_y, n_min_z;
  logic signed [COORD_BITS-1:0] n_max_x, n_max_y, n_max_z;
  logic             n_leaf;
  logic [SkipW-1:0] n_skip;
  logic             overlap;
  logic             leaf_hit;
  logic [SkipW-1:0] step;
  logic [IdxW-1:0]  next_idx;
  logic [LimW-1:0]  n_inc;
  logic [LimW-1:0]  lim_sat;
  logic [IdxW-1:0]  cnt_sat;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != StIdle);

  assign wr_en = accept && (op_i == bvhbox_pkg::OpWrite) &&
                 (32'(node_addr_i) < NODE_DEPTH);
  assign wr_entry = {node_is_leaf_i, node_skip_i,
                     max_z_i, max_y_i, max_x_i, min_z_i, min_y_i, min_x_i};

  bvhbox_ram #(
    .WIDTH (EntryW),
    .DEPTH (NODE_DEPTH)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AddrW'(node_addr_i)),
    .wdata_i (wr_entry),
    .raddr_i (rd_addr),
    .rdata_o (rd_entry)
  );

  assign n_min_x = rd_entry[0*COORD_BITS +: COORD_BITS];
  assign n_min_y = rd_entry[1*COORD_BITS +: COORD_BITS];
  assign n_min_z = rd_entry[2*COORD_BITS +: COORD_BITS];
  assign n_max_x = rd_entry[3*COORD_BITS +: COORD_BITS];
  assign n_max_y = rd_entry[4*COORD_BITS +: COORD_BITS];
  assign n_max_z = rd_entry[5*COORD_BITS +: COORD_BITS];
  assign n_skip  = rd_entry[OffSkip +: SkipW];
  assign n_leaf  = rd_entry[OffLeaf];

  // inclusive test on all three axes
  assign overlap = (q_min_x_q <= n_max_x) && (q_max_x_q >= n_min_x) &&
                   (q_min_y_q <= n_max_y) && (q_max_y_q >= n_min_y) &&
                   (q_min_z_q <= n_max_z) && (q_max_z_q >= n_min_z);
  assign leaf_hit = overlap && n_leaf;

  // a missing inner node jumps over its subtree, zero skip counts as one
  assign step = (overlap || n_leaf || (n_skip == '0)) ? SkipW'(1) : n_skip;
  assign next_idx = IdxW'(idx_q) + IdxW'(step);
  assign n_inc = n_q + LimW'(1);

  assign lim_sat = (32'(max_hits_i) > HIT_LIMIT) ? LimW'(HIT_LIMIT) : LimW'(max_hits_i);
  assign cnt_sat = (32'(node_count_q) > NODE_DEPTH) ? IdxW'(NODE_DEPTH)
                                                     : IdxW'(node_count_q);

  // the walk issues the next read from the entry just returned
  assign rd_addr = (state_q == StWalk) ? next_idx[AddrW-1:0] : '0;

  always_comb begin
    state_d      = state_q;
    limit_d      = limit_q;
    n_d          = n_q;
    count_d      = count_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_node_d  = pend_node_q;
    out_valid_d  = 1'b0;
    out_node_d   = leaf_node_o;
    out_hit_d    = hit_o;
    out_last_d   = last_o;
    case (state_q)
      StIdle: begin
        if (accept && (op_i == bvhbox_pkg::OpQuery)) begin
          limit_d      = lim_sat;
          count_d      = cnt_sat;
          n_d          = '0;
          idx_d        = '0;
          pend_valid_d = 1'b0;
          if ((lim_sat == '0) || (cnt_sat == '0)) begin
            state_d = StFin;
          end else begin
            state_d = StWalk;
          end
        end
      end
      StWalk: begin
        if (leaf_hit) begin
          // previous hit goes out now that another one follows it
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_node_d  = bvhbox_pkg::NodeAddrW'(pend_node_q);
            out_hit_d   = 1'b1;
            out_last_d  = 1'b0;
          end
          pend_valid_d = 1'b1;
          pend_node_d  = idx_q;
          n_d          = n_inc;
        end
        if ((leaf_hit && (n_inc == limit_q)) || (next_idx >= count_q)) begin
          state_d = StFin;
        end else begin
          idx_d = next_idx[AddrW-1:0];
        end
      end
      StFin: begin
        out_valid_d = 1'b1;
        out_last_d  = 1'b1;
        if (pend_valid_q) begin
          out_node_d = bvhbox_pkg::NodeAddrW'(pend_node_q);
          out_hit_d  = 1'b1;
        end else begin
          out_node_d = '0;
          out_hit_d  = 1'b0;
        end
        pend_valid_d = 1'b0;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      node_count_q <= '0;
      pend_valid_q <= 1'b0;
      valid_o      <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      valid_o      <= out_valid_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (op_i == bvhbox_pkg::OpQuery)) begin
      q_min_x_q <= min_x_i;
      q_min_y_q <= min_y_i;
      q_min_z_q <= min_z_i;
      q_max_x_q <= max_x_i;
      q_max_y_q <= max_y_i;
      q_max_z_q <= max_z_i;
    end
    limit_q     <= limit_d;
    n_q         <= n_d;
    count_q     <= count_d;
    idx_q       <= idx_d;
    pend_node_q <= pend_node_d;
    leaf_node_o <= out_node_d;
    hit_o       <= out_hit_d;
    last_o      <= out_last_d;
  end

  // the final result of a query only shows once the walk has ended
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |-> !busy_o)
    else $error("last result while walk still running");

  // an earlier hit only goes out while the walk is still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> busy_o && hit_o)
    else $error("non-final result outside a walk");

  // the hit counter stays below the limit during a walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) |-> (n_q < limit_q))
    else $error("hit count reached limit inside walk");

  // an empty answer is always the final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !hit_o |-> last_o && (leaf_node_o == '0))
    else $error("empty answer not final");

endmodule

`default_nettype wire
